### design/msw_pkg.sv
`timescale 1ns / 1ps
package msw_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned PORT_BITS     = 8;
  localparam int unsigned MAC_W         = 48;
  localparam int unsigned PORT_W        = 8;
  localparam int unsigned GROUP_BIT     = 40;

  // one request travelling down the row of entries
  typedef struct packed {
    logic              valid;
    logic              learned;
    logic              hit;
    logic              dst_group;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] port;
    logic [PORT_W-1:0] hit_port;
  } req_t;

endpackage

### design/msw_cell.sv
`timescale 1ns / 1ps
module msw_cell #(
  parameter int unsigned PortBits = msw_pkg::PORT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  msw_pkg::req_t req_i,
  output msw_pkg::req_t req_o,
  output logic          valid_o
);
  import msw_pkg::*;

  localparam int unsigned StoreW = (PortBits < PORT_W) ? PortBits : PORT_W;

  logic              valid_q;
  logic [MAC_W-1:0]  mac_q;
  logic [StoreW-1:0] port_q;
  logic              learn_on;
  logic              fill;
  logic              src_match;
  logic              wr;
  logic              valid_new;
  logic [MAC_W-1:0]  mac_new;
  logic [StoreW-1:0] port_new;
  req_t              req_d;
  req_t              req_q;

  always_comb begin
    learn_on  = req_i.valid && !req_i.learned;
    fill      = learn_on && !valid_q;
    src_match = learn_on && valid_q && (mac_q == req_i.src_mac);
    wr        = fill || src_match;
    valid_new = valid_q || fill;
    mac_new   = fill ? req_i.src_mac : mac_q;
    port_new  = wr ? req_i.port[StoreW-1:0] : port_q;

    req_d         = req_i;
    req_d.learned = req_i.learned || wr;
    // lookup sees this entry after the learn of the same request
    if (req_i.valid && !req_i.hit && valid_new && (mac_new == req_i.dst_mac)) begin
      req_d.hit      = 1'b1;
      req_d.hit_port = PORT_W'(port_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      req_q   <= '0;
    end else begin
      valid_q <= valid_new;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      mac_q <= req_i.src_mac;
    end
    if (wr) begin
      port_q <= req_i.port[StoreW-1:0];
    end
  end

  assign req_o   = req_q;
  assign valid_o = valid_q;

endmodule

### design/mac_learning_switch_table_core.sv
`timescale 1ns / 1ps
// channel  direction  ports                             handshake
// request  in         src_mac_i dst_mac_i in_port_i     start_i && !busy_o
// result   out        flood_o egress_port_o             done_o, one cycle
//
// a request enters every cycle; busy_o stays low
// the request walks the row of TableEntries entry cells, each of which registers it,
// one cell per cycle, learning and looking up as it passes
// a later request trails an earlier one by a cell, so it sees its updates
// reset clears all entry valid bits and the pipeline at once
// the receiver cannot stall; one result per request, in order
module mac_learning_switch_table_core #(
  parameter int unsigned TableEntries = msw_pkg::TABLE_ENTRIES,
  parameter int unsigned PortBits     = msw_pkg::PORT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [msw_pkg::MAC_W-1:0]    src_mac_i,
  input  logic [msw_pkg::MAC_W-1:0]    dst_mac_i,
  input  logic [msw_pkg::PORT_W-1:0]   in_port_i,
  output logic                         done_o,
  output logic                         flood_o,
  output logic [msw_pkg::PORT_W-1:0]   egress_port_o
);
  import msw_pkg::*;

  localparam int unsigned StoreW = (PortBits < PORT_W) ? PortBits : PORT_W;

  req_t                    chain [TableEntries+1];
  req_t                    head;
  logic [TableEntries-1:0] valid_vec;
  req_t                    last;

  assign busy_o = 1'b0;

  always_comb begin
    head           = '0;
    head.valid     = start_i && !busy_o;
    // group source is never learned
    head.learned   = src_mac_i[GROUP_BIT];
    head.dst_group = dst_mac_i[GROUP_BIT];
    head.src_mac   = src_mac_i;
    head.dst_mac   = dst_mac_i;
    head.port      = PORT_W'(in_port_i[StoreW-1:0]);
  end

  assign chain[0] = head;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    msw_cell #(
      .PortBits(PortBits)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (chain[g]),
      .req_o  (chain[g+1]),
      .valid_o(valid_vec[g])
    );
  end

  assign last          = chain[TableEntries];
  assign done_o        = last.valid;
  assign flood_o       = last.dst_group || !last.hit;
  assign egress_port_o = flood_o ? '0 : last.hit_port;

  // entries fill from the bottom with no holes
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + TableEntries'(1))) == '0)
    else $error("entry valid bits not contiguous");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, TableEntries))
    else $error("result without matching request");

  a_group_floods: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && last.dst_group) |-> (flood_o && (egress_port_o == '0)))
    else $error("group destination not flooded");

endmodule
